// File: hw/rtl/sdg_pkg.sv
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared widths, command codes, constants and bundle types of the step and
// direction pulse generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sdg_pkg;

   localparam int PULSE_WIDTH = 5;

   localparam int PERIOD_W   = 20;
   localparam int SPR_W      = 16;
   localparam int ANGLE_W    = 24;
   localparam int POS_W      = 32;
   localparam int CMD_W      = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USED_W = 5 + POS_W;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1250);
   localparam logic [SPR_W-1:0]    SPR_RESET    = SPR_W'(200);

   localparam logic [PERIOD_W-1:0] PW_TICKS   = PERIOD_W'(PULSE_WIDTH);
   localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(PULSE_WIDTH + 1);

   // One full turn is 360 degrees in steps of 1/256 degree, that is 45 * 2^11.
   localparam int DEG_FULL_Q8 = 360 * 256;
   localparam int DIV_SHIFT   = 11;
   localparam int DIV_ODD     = DEG_FULL_Q8 >> DIV_SHIFT;

   localparam int PROD_W  = ANGLE_W + SPR_W;
   localparam int NUM_W   = PROD_W - DIV_SHIFT;
   localparam int STEPS_W = 23;

   localparam logic [PROD_W-1:0] MOVE_MIN = PROD_W'(DEG_FULL_Q8);

   // Reciprocal of 45, exact for every numerator below 2^NUM_W.
   localparam int RECIP_K = NUM_W + 6;
   localparam int RECIP_W = 30;
   localparam logic [63:0] RECIP_M64 =
      ((64'd1 << RECIP_K) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_M64[RECIP_W-1:0];
   localparam int MUL_W = NUM_W + RECIP_W;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PERIOD   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_REV = CSR_IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_ENGAGE     = 3'd1,
      CMD_DISENGAGE  = 3'd2,
      CMD_MOVE       = 3'd3,
      CMD_CONTINUOUS = 3'd4,
      CMD_STOP       = 3'd5,
      CMD_CLEAR      = 3'd6
   } sdg_cmd_type;

   typedef struct packed {
      logic              vld;
      sdg_cmd_type       cmd;
      logic              fwd;
      logic              move_dir;
      logic [PROD_W-1:0] prod;
   } sdg_item_type;

   typedef struct packed {
      logic             vld;
      logic [NUM_W-1:0] num;
   } sdg_div_req_type;

   typedef struct packed {
      logic               vld;
      logic [STEPS_W-1:0] steps;
   } sdg_steps_type;

endpackage

`default_nettype wire

// File: hw/rtl/sdg_in_stage.sv
// ----------------------------------------------------------------------------
// sdg_in_stage
// Input register of the request stream; forms the angle magnitude, the move
// direction and the product of magnitude and steps per revolution.
// ----------------------------------------------------------------------------
`default_nettype none

module sdg_in_stage import sdg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [CMD_W-1:0]      req_tuser,
   input  wire logic [SPR_W-1:0]      steps_per_rev,
   input  wire logic                  core_ready,
   output sdg_item_type               item
);

   logic                in_vld_ff;
   logic                in_vld_in;
   sdg_item_type        item_ff;
   sdg_item_type        item_in;
   logic [ANGLE_W-1:0]  angle;
   logic [ANGLE_W-1:0]  mag;
   logic                accept;

   assign req_tready = !in_vld_ff || core_ready;
   assign accept     = req_tvalid && req_tready;
   assign angle      = req_tdata[ANGLE_W-1:0];
   assign mag        = angle[ANGLE_W-1] ? (~angle + ANGLE_W'(1)) : angle;

   always_comb begin
      item_in          = item_ff;
      item_in.vld      = 1'b0;
      if (accept) begin
         item_in.cmd      = sdg_cmd_type'(req_tuser);
         item_in.fwd      = req_tdata[ANGLE_W];
         item_in.move_dir = req_tdata[ANGLE_W] ^ angle[ANGLE_W-1];
         item_in.prod     = mag * steps_per_rev;
      end
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (core_ready) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      item_ff <= item_in;
   end

   always_comb begin
      item     = item_ff;
      item.vld = in_vld_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/sdg_div45.sv
// ----------------------------------------------------------------------------
// sdg_div45
// Two-stage divide by 45 through a reciprocal multiply; turns the scaled
// angle product into the step count of a counted move.
// ----------------------------------------------------------------------------
`default_nettype none

module sdg_div45 import sdg_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sdg_div_req_type div_req,
   output sdg_steps_type        steps_load
);

   logic               v1_ff;
   logic               v2_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [STEPS_W-1:0] quot_ff;
   logic [STEPS_W-1:0] quot_in;
   logic [MUL_W-1:0]   mul;

   assign mul     = num_ff * RECIP_M;
   assign quot_in = mul[RECIP_K +: STEPS_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= div_req.vld;
         v2_ff <= v1_ff;
      end
      num_ff  <= div_req.num;
      quot_ff <= quot_in;
   end

   assign steps_load = {v2_ff, quot_ff};

endmodule

`default_nettype wire

// File: hw/rtl/sdg_core.sv
// ----------------------------------------------------------------------------
// sdg_core
// Motion state, command decode and tick handling, with the result register
// that drives the response stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sdg_core import sdg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sdg_item_type          item,
   output logic                       core_ready,
   input  wire logic [PERIOD_W-1:0]   step_period,
   input  wire sdg_steps_type         steps_load,
   output sdg_div_req_type            div_req,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  enabled_ff, enabled_in;
   logic                  running_ff, running_in;
   logic                  cont_ff, cont_in;
   logic                  stop_ff, stop_in;
   logic                  dir_ff, dir_in;
   logic [STEPS_W-1:0]    steps_left_ff, steps_left_in;
   logic [PERIOD_W-1:0]   ticks_ff, ticks_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  take;
   logic                  acc;
   logic [PERIOD_W-1:0]   eff_period;
   logic [PERIOD_W-1:0]   ticks_inc;
   logic [POS_W-1:0]      pos_step;

   assign core_ready = !rsp_vld_ff || rsp_tready;
   assign take       = item.vld && core_ready;
   assign eff_period = (step_period < MIN_PERIOD) ? MIN_PERIOD : step_period;
   assign ticks_inc  = ticks_ff + PERIOD_W'(1);
   assign pos_step   = dir_ff ? (pos_ff + POS_W'(1)) : (pos_ff - POS_W'(1));

   always_comb begin
      enabled_in    = enabled_ff;
      running_in    = running_ff;
      cont_in       = cont_ff;
      stop_in       = stop_ff;
      dir_in        = dir_ff;
      steps_left_in = steps_left_ff;
      ticks_in      = ticks_ff;
      pos_in        = pos_ff;
      acc           = 1'b0;
      div_req.vld   = 1'b0;
      div_req.num   = item.prod[PROD_W-1:DIV_SHIFT];

      if (take) begin
         unique case (item.cmd)
            CMD_TICK: begin
               if (running_ff) begin
                  if (cont_ff) begin
                     if (ticks_inc == PW_TICKS) begin
                        pos_in = pos_step;
                     end
                     if (ticks_inc == PW_TICKS && stop_ff) begin
                        running_in = 1'b0;
                        stop_in    = 1'b0;
                        cont_in    = 1'b0;
                        ticks_in   = '0;
                     end else begin
                        ticks_in = (ticks_inc >= eff_period) ? '0 : ticks_inc;
                     end
                  end else if (ticks_inc >= eff_period) begin
                     ticks_in      = '0;
                     pos_in        = pos_step;
                     steps_left_in = steps_left_ff - STEPS_W'(1);
                     if (steps_left_ff == STEPS_W'(1) || stop_ff) begin
                        running_in = 1'b0;
                        stop_in    = 1'b0;
                        cont_in    = 1'b0;
                     end
                  end else begin
                     ticks_in = ticks_inc;
                  end
               end
            end
            CMD_ENGAGE: begin
               enabled_in = 1'b1;
               acc        = 1'b1;
            end
            CMD_DISENGAGE: begin
               enabled_in = 1'b0;
               acc        = 1'b1;
            end
            CMD_MOVE: begin
               if (enabled_ff && !running_ff && item.prod >= MOVE_MIN) begin
                  running_in  = 1'b1;
                  cont_in     = 1'b0;
                  stop_in     = 1'b0;
                  dir_in      = item.move_dir;
                  ticks_in    = '0;
                  acc         = 1'b1;
                  div_req.vld = 1'b1;
               end
            end
            CMD_CONTINUOUS: begin
               if (enabled_ff && !running_ff) begin
                  running_in = 1'b1;
                  cont_in    = 1'b1;
                  stop_in    = 1'b0;
                  dir_in     = item.fwd;
                  ticks_in   = '0;
                  acc        = 1'b1;
               end
            end
            CMD_STOP: begin
               if (running_ff) begin
                  acc = 1'b1;
                  if (cont_ff && ticks_ff >= PW_TICKS) begin
                     running_in = 1'b0;
                     stop_in    = 1'b0;
                     cont_in    = 1'b0;
                     ticks_in   = '0;
                  end else begin
                     stop_in = 1'b1;
                  end
               end
            end
            CMD_CLEAR: begin
               pos_in = '0;
               acc    = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // The step count arrives from the divider long before the first
      // period of the move can end.
      if (steps_load.vld) begin
         steps_left_in = steps_load.steps;
      end

      rsp_data_in = rsp_data_ff;
      if (take) begin
         rsp_data_in = {(RSP_DATA_W - RSP_USED_W)'(0), acc, pos_in, running_in,
                        !enabled_in, dir_in, running_in && (ticks_in < PW_TICKS)};
      end

      if (take) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         running_ff    <= 1'b0;
         cont_ff       <= 1'b0;
         stop_ff       <= 1'b0;
         dir_ff        <= 1'b0;
         steps_left_ff <= '0;
         ticks_ff      <= '0;
         pos_ff        <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         enabled_ff    <= enabled_in;
         running_ff    <= running_in;
         cont_ff       <= cont_in;
         stop_ff       <= stop_in;
         dir_ff        <= dir_in;
         steps_left_ff <= steps_left_in;
         ticks_ff      <= ticks_in;
         pos_ff        <= pos_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/stepper_step_dir_generator_unit.sv
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_unit
// Step and direction pulse generator for a stepper driver, fed by tick words
// and command words.
// ----------------------------------------------------------------------------
// The unit takes one request word every clock cycle, each tick word standing
// for one microsecond, and returns exactly one response word per request once
// it has passed the input register, where the angle product is multiplied out,
// and the state and result register. A full response register does not stop
// intake; only a response held back by rsp_tready for more than one word
// stalls req_tready. The step count of a counted move is produced by a
// two-stage reciprocal divider and is in place before the first step period
// can end.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_step_dir_generator_unit import sdg_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // angle_q8 [23:0], forward [24], zero [31:25]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [2:0]
   input  wire logic [CMD_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // step_level [0], dir_level [1], enable_n [2], is_moving [3],
   // position_count [35:4], accepted [36], zero [39:37]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_addr,
   input  wire logic [PERIOD_W-1:0]   csr_wdata
);

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [SPR_W-1:0]    spr_ff, spr_in;
   sdg_item_type        item;
   logic                core_ready;
   sdg_div_req_type     div_req;
   sdg_steps_type       steps_load;

   always_comb begin
      period_in = period_ff;
      spr_in    = spr_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_PERIOD:   period_in = csr_wdata;
            CSR_STEPS_PER_REV: spr_in    = csr_wdata[SPR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         spr_ff    <= SPR_RESET;
      end else begin
         period_ff <= period_in;
         spr_ff    <= spr_in;
      end
   end

   sdg_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .steps_per_rev (spr_ff),
      .core_ready    (core_ready),
      .item          (item)
   );

   sdg_div45 u_div45 (
      .clock      (clock),
      .reset      (reset),
      .div_req    (div_req),
      .steps_load (steps_load)
   );

   sdg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item        (item),
      .core_ready  (core_ready),
      .step_period (period_ff),
      .steps_load  (steps_load),
      .div_req     (div_req),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && !rsp_tdata[3]))
      else $error("step pulse reported while not moving");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with an empty response register");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      steps_load.vld |-> !div_req.vld)
      else $error("counted move started while a step count was in flight");

endmodule

`default_nettype wire

// File: sim/tb_stepper_step_dir_generator_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_step_dir_generator_unit
// Self-checking bench for the step and direction pulse generator.
// ----------------------------------------------------------------------------
// A queue of tick and command words feeds a clocked driver. Each word that the
// unit takes is run through a cycle-free model of the motor state, and the
// pin word that it predicts is queued. A clocked monitor pops the oldest
// prediction for every returned word and compares it field by field. The run
// walks through a directed opening and several random phases with different
// step periods, steps per revolution and amounts of idling on both sides.
// ----------------------------------------------------------------------------

module tb_stepper_step_dir_generator_unit;
   import sdg_pkg::*;

   localparam int          HOLD_CYCLES  = 200;
   localparam int          END_CYCLES   = 8;
   localparam longint      Q8_PER_TURN  = 92160;

   typedef struct {
      sdg_cmd_type        cmd;
      logic [ANGLE_W-1:0] angle;
      logic               fwd;
   } cmd_word_type;

   typedef struct {
      logic             step;
      logic             dir;
      logic             enable_n;
      logic             moving;
      logic [POS_W-1:0] pos;
      logic             acc;
   } pin_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = CSR_STEP_PERIOD;
   logic [PERIOD_W-1:0]   csr_wdata = '0;

   cmd_word_type cmd_word_q[$];
   pin_word_type pin_state_q[$];
   cmd_word_type offered_word;

   int  req_idle_pct = 0;
   int  rsp_stall_pct = 0;
   int  mismatch_count = 0;
   logic hold_start = 1'b0;
   int  hold_left = 0;

   // Motor model state and its copy of the registers.
   logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
   logic [SPR_W-1:0]    cfg_spr = SPR_RESET;
   logic                mot_enabled = 1'b0;
   logic                mot_running = 1'b0;
   logic                mot_cont = 1'b0;
   logic                mot_stop = 1'b0;
   logic                mot_dir = 1'b0;
   logic [31:0]         mot_steps_left = '0;
   logic [PERIOD_W-1:0] mot_ticks = '0;
   logic [POS_W-1:0]    mot_pos = '0;

   stepper_step_dir_generator_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void halt_motor();
      mot_running = 1'b0;
      mot_stop = 1'b0;
      mot_cont = 1'b0;
      mot_ticks = '0;
   endfunction

   function automatic void bump_position();
      mot_pos = mot_dir ? mot_pos + 32'd1 : mot_pos - 32'd1;
   endfunction

   function automatic pin_word_type advance_motor(input cmd_word_type w);
      pin_word_type        r;
      logic [PERIOD_W-1:0] eff;
      logic [24:0]         mag;
      logic                dir;
      longint unsigned     steps;
      logic                acc;
      eff = (cfg_period < PERIOD_W'(PULSE_WIDTH + 1)) ? PERIOD_W'(PULSE_WIDTH + 1)
                                                      : cfg_period;
      acc = 1'b0;
      case (w.cmd)
         CMD_TICK: begin
            if (mot_running) begin
               mot_ticks = mot_ticks + 1'b1;
               if (mot_cont) begin
                  if (mot_ticks == PERIOD_W'(PULSE_WIDTH)) begin
                     bump_position();
                     if (mot_stop) halt_motor();
                  end
                  if (mot_ticks >= eff) mot_ticks = '0;
               end else if (mot_ticks >= eff) begin
                  mot_ticks = '0;
                  bump_position();
                  mot_steps_left = mot_steps_left - 1;
                  if (mot_steps_left == 0 || mot_stop) halt_motor();
               end
            end
         end
         CMD_ENGAGE: begin
            mot_enabled = 1'b1;
            acc = 1'b1;
         end
         CMD_DISENGAGE: begin
            mot_enabled = 1'b0;
            acc = 1'b1;
         end
         CMD_MOVE: begin
            if (mot_enabled && !mot_running) begin
               dir = w.fwd;
               if (w.angle[ANGLE_W-1]) begin
                  mag = 25'h1000000 - {1'b0, w.angle};
                  dir = !dir;
               end else begin
                  mag = {1'b0, w.angle};
               end
               steps = (longint'(mag) * longint'(cfg_spr)) / Q8_PER_TURN;
               if (steps != 0) begin
                  mot_running = 1'b1;
                  mot_cont = 1'b0;
                  mot_stop = 1'b0;
                  mot_dir = dir;
                  mot_steps_left = 32'(steps);
                  mot_ticks = '0;
                  acc = 1'b1;
               end
            end
         end
         CMD_CONTINUOUS: begin
            if (mot_enabled && !mot_running) begin
               mot_running = 1'b1;
               mot_cont = 1'b1;
               mot_stop = 1'b0;
               mot_dir = w.fwd;
               mot_steps_left = '0;
               mot_ticks = '0;
               acc = 1'b1;
            end
         end
         CMD_STOP: begin
            if (mot_running) begin
               acc = 1'b1;
               if (mot_cont && mot_ticks >= PERIOD_W'(PULSE_WIDTH)) halt_motor();
               else mot_stop = 1'b1;
            end
         end
         CMD_CLEAR: begin
            mot_pos = '0;
            acc = 1'b1;
         end
         default: begin
         end
      endcase
      r.step = mot_running && (mot_ticks < PERIOD_W'(PULSE_WIDTH));
      r.dir = mot_dir;
      r.enable_n = !mot_enabled;
      r.moving = mot_running;
      r.pos = mot_pos;
      r.acc = acc;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pin_state_q.push_back(advance_motor(offered_word));
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_word_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               offered_word = cmd_word_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, offered_word.fwd, offered_word.angle};
               req_tuser <= offered_word.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      pin_word_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pin_state_q.size() == 0) begin
               $error("response word with no prediction: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               e = pin_state_q.pop_front();
               if (rsp_tdata[0] !== e.step) begin
                  $error("step_level expected %0d got %0d", e.step, rsp_tdata[0]);
                  mismatch_count++;
               end
               if (rsp_tdata[1] !== e.dir) begin
                  $error("dir_level expected %0d got %0d", e.dir, rsp_tdata[1]);
                  mismatch_count++;
               end
               if (rsp_tdata[2] !== e.enable_n) begin
                  $error("enable_n expected %0d got %0d", e.enable_n, rsp_tdata[2]);
                  mismatch_count++;
               end
               if (rsp_tdata[3] !== e.moving) begin
                  $error("is_moving expected %0d got %0d", e.moving, rsp_tdata[3]);
                  mismatch_count++;
               end
               if (rsp_tdata[35:4] !== e.pos) begin
                  $error("position_count expected %0d got %0d",
                         $signed(e.pos), $signed(rsp_tdata[35:4]));
                  mismatch_count++;
               end
               if (rsp_tdata[36] !== e.acc) begin
                  $error("accepted expected %0d got %0d", e.acc, rsp_tdata[36]);
                  mismatch_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic push(input sdg_cmd_type cmd, input logic [ANGLE_W-1:0] angle,
                       input logic fwd);
      cmd_word_type w;
      w.cmd = cmd;
      w.angle = angle;
      w.fwd = fwd;
      cmd_word_q.push_back(w);
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push(CMD_TICK, 24'($urandom), 1'($urandom));
   endtask

   function automatic cmd_word_type random_word(input bit allow_move);
      cmd_word_type w;
      int unsigned  pick;
      int unsigned  k;
      int unsigned  mag;
      w.cmd = CMD_TICK;
      w.angle = 24'($urandom);
      w.fwd = 1'($urandom);
      pick = $urandom_range(99);
      if (pick < 8) begin
         w.cmd = CMD_ENGAGE;
      end else if (pick < 10) begin
         w.cmd = CMD_DISENGAGE;
      end else if (pick < 17 && allow_move) begin
         w.cmd = CMD_MOVE;
         case ($urandom_range(9))
            0: begin
            end
            1: w.angle = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: begin
               k = $urandom_range(4);
               mag = (k * 92160 + $urandom_range(92159)) / cfg_spr;
               w.angle = $urandom_range(1) ? 24'(-mag) : 24'(mag);
            end
         endcase
      end else if (pick < 21) begin
         w.cmd = CMD_CONTINUOUS;
      end else if (pick < 25) begin
         w.cmd = CMD_STOP;
      end else if (pick < 26) begin
         w.cmd = CMD_CLEAR;
      end
      return w;
   endfunction

   task automatic push_random(input int n, input bit allow_move);
      repeat (n) cmd_word_q.push_back(random_word(allow_move));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PERIOD_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STEP_PERIOD) cfg_period = val;
      else cfg_spr = val[SPR_W-1:0];
   endtask

   task automatic drain();
      while (cmd_word_q.size() != 0 || pin_state_q.size() != 0 || req_tvalid)
         @(posedge clock);
   endtask

   task automatic run_phase(input logic [PERIOD_W-1:0] period, input logic [SPR_W-1:0] spr,
                            input int idle, input int stall, input int n,
                            input bit allow_move);
      drain();
      write_csr(CSR_STEP_PERIOD, period);
      write_csr(CSR_STEPS_PER_REV, PERIOD_W'(spr));
      req_idle_pct = idle;
      rsp_stall_pct = stall;
      push_random(n, allow_move);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // The short period is raised to one tick more than the pulse width.
      write_csr(CSR_STEP_PERIOD, 20'd2);
      write_csr(CSR_STEPS_PER_REV, 20'd65535);
      push_ticks(1);
      push(CMD_MOVE, 24'h7FFFFF, 1'b1);
      push(CMD_CONTINUOUS, '0, 1'b1);
      push(CMD_STOP, '0, 1'b0);
      push(CMD_ENGAGE, '0, 1'b0);
      push(CMD_MOVE, 24'h000000, 1'b1);
      push(CMD_MOVE, 24'h000001, 1'b1);
      push(CMD_CONTINUOUS, '0, 1'b1);
      push(CMD_MOVE, 24'h00FFFF, 1'b1);
      push_ticks(2);
      push(CMD_STOP, '0, 1'b0);
      push_ticks(3);
      push(CMD_MOVE, 24'hFFFFFE, 1'b1);
      push_ticks(6);
      push(CMD_CONTINUOUS, '0, 1'b0);
      push_ticks(5);
      push(CMD_STOP, '0, 1'b1);
      push(CMD_MOVE, 24'h800000, 1'b0);
      push_ticks(1);
      push(CMD_DISENGAGE, '0, 1'b0);
      push_ticks(1);
      push(CMD_STOP, '0, 1'b0);
      push_ticks(4);
      push(CMD_ENGAGE, '0, 1'b1);
      push(CMD_CLEAR, '0, 1'b0);

      // The receiver holds off for a long stretch while words keep coming.
      run_phase(20'd8, 16'd200, 0, 0, 250, 1'b1);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;

      run_phase(20'hFFFFF, 16'd1, 81, 0, 100, 1'b0);
      push(CMD_ENGAGE, '0, 1'b0);
      push(CMD_CONTINUOUS, '0, 1'b1);
      push_ticks(20);

      // A running period counter now sits beyond the shorter period.
      run_phase(20'd6, 16'd1, 0, 81, 250, 1'b1);
      run_phase(20'd13, 16'd65535, 23, 23, 250, 1'b1);
      run_phase(20'd2, 16'd3600, 0, 0, 150, 1'b1);

      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS stepper_step_dir_generator_unit");
      end else begin
         $display("FAIL stepper_step_dir_generator_unit");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL stepper_step_dir_generator_unit");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/sdg_pkg.sv
hw/rtl/sdg_in_stage.sv
hw/rtl/sdg_div45.sv
hw/rtl/sdg_core.sv
hw/rtl/stepper_step_dir_generator_unit.sv
sim/tb_stepper_step_dir_generator_unit.sv
